[rtl/core/psca_pkg.sv]
package psca_pkg;

  localparam int ADDR_W  = 16;
  localparam int REQ_W   = 13;
  localparam int BYTES_W = 17;
  localparam int LINK_W  = 17;
  localparam int CLS_W   = 5;
  localparam int DEPTH   = 1 << ADDR_W;

  localparam logic [LINK_W-1:0] EMPTY_MARK = 17'h10000;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_PAGES  = 2'd2,
    STAT_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WB
  } state_t;

  typedef struct packed {
    logic              in_use;
    logic [CLS_W-1:0]  cls;
    logic [LINK_W-1:0] link;
  } entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // Smallest k with 2^k >= n, where zero counts as one.
  function automatic logic [CLS_W-1:0] class_of(input logic [REQ_W-1:0] n);
    logic [REQ_W-1:0] m;
    logic [CLS_W-1:0] k;
    m = (n == '0) ? '0 : n - REQ_W'(1);
    k = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (m[i]) k = CLS_W'(i + 1);
    end
    return k;
  endfunction

endpackage

[rtl/core/psca_blk_mem.sv]
module psca_blk_mem (
  input  logic               clk,
  input  psca_pkg::mem_req_t req,
  output psca_pkg::entry_t   rd_data
);
  import psca_pkg::*;

  entry_t ram [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) ram[req.wr_addr] <= req.wr_data;
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data_r <= ram[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/pow2_size_class_allocator_core.sv]
// Channel   Handshake             Payload
// input     start & !busy         in_command, in_request_bytes, in_free_address
// result    out_valid (1 cycle)   out_status, out_block_address, out_block_bytes,
//                                 out_allocated_bytes, out_used_bytes
// After reset every entry of the block memory is cleared while busy is high.
// An allocate served by carving, or a rejected allocate, keeps busy high only in
// S_EXEC; a stack pop or any free keeps it high in S_EXEC and S_WB, bound by the
// read-modify-write on the block memory.
// The result is valid in the first cycle with busy low and lasts one cycle; the
// receiver cannot stall it.
module pow2_size_class_allocator_core #(
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_PAGES   = 16,
  parameter int NUM_CLASSES = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_command,
  input  logic [psca_pkg::REQ_W-1:0] in_request_bytes,
  input  logic [psca_pkg::ADDR_W-1:0] in_free_address,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [psca_pkg::ADDR_W-1:0] out_block_address,
  output logic [psca_pkg::REQ_W-1:0] out_block_bytes,
  output logic [psca_pkg::BYTES_W-1:0] out_allocated_bytes,
  output logic [psca_pkg::BYTES_W-1:0] out_used_bytes
);
  import psca_pkg::*;

  localparam int KW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int LEFT_W = $clog2(PAGE_BYTES + 1);

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              cmd_r;
  logic [CLS_W-1:0]  k_r;
  logic [ADDR_W-1:0] faddr_r;

  logic [LINK_W-1:0] head_r  [NUM_CLASSES];
  logic [PG_W-1:0]   cpage_r [NUM_CLASSES];
  logic [LEFT_W-1:0] cleft_r [NUM_CLASSES];
  logic [CNT_W-1:0]  pages_r, pages_nxt;
  logic [BYTES_W-1:0] alloc_r, alloc_nxt;
  logic [BYTES_W-1:0] used_r, used_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [REQ_W-1:0]   out_bytes_r, out_bytes_nxt;

  logic              head_we, carve_we;
  logic [KW-1:0]     head_idx;
  logic [LINK_W-1:0] head_wd;
  logic [PG_W-1:0]   cpage_wd;
  logic [LEFT_W-1:0] cleft_wd;

  mem_req_t mreq;
  entry_t   rd_data;

  logic [KW-1:0]      kidx, fidx;
  logic [BYTES_W-1:0] size_k, size_f;
  logic               too_large, claim;
  logic [PG_W-1:0]    pg;
  logic [LEFT_W-1:0]  left0, left1;
  logic [ADDR_W-1:0]  carve_addr;

  psca_blk_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  assign kidx   = k_r[KW-1:0];
  assign fidx   = rd_data.cls[KW-1:0];
  assign size_k = BYTES_W'(1) << k_r;
  assign size_f = BYTES_W'(1) << rd_data.cls;
  assign too_large = (k_r >= CLS_W'(NUM_CLASSES)) || (size_k > BYTES_W'(PAGE_BYTES));
  assign claim  = (cleft_r[kidx] == '0);
  assign pg     = claim ? pages_r[PG_W-1:0] : cpage_r[kidx];
  assign left0  = claim ? (LEFT_W'(PAGE_BYTES) >> k_r) : cleft_r[kidx];
  assign left1  = left0 - LEFT_W'(1);
  assign carve_addr = ADDR_W'(ADDR_W'(pg) * ADDR_W'(PAGE_BYTES))
                    + ADDR_W'({{ADDR_W{1'b0}}, left1} << k_r);

  always_comb begin
    state_nxt      = state_r;
    pages_nxt      = pages_r;
    alloc_nxt      = alloc_r;
    used_nxt       = used_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_bytes_nxt  = out_bytes_r;
    head_we        = 1'b0;
    head_idx       = kidx;
    head_wd        = head_r[kidx];
    carve_we       = 1'b0;
    cpage_wd       = pg;
    cleft_wd       = left1;
    mreq           = '0;

    unique case (state_r)
      S_CLEAR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = clr_cnt_r;
        if (clr_cnt_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_r == CMD_FREE) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = faddr_r;
          state_nxt    = S_WB;
        end else if (too_large) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_TOO_LARGE;
          out_addr_nxt   = '0;
          out_bytes_nxt  = '0;
          state_nxt      = S_IDLE;
        end else if (head_r[kidx] != EMPTY_MARK) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = head_r[kidx][ADDR_W-1:0];
          state_nxt    = S_WB;
        end else if (claim && (pages_r >= CNT_W'(MAX_PAGES))) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NO_PAGES;
          out_addr_nxt   = '0;
          out_bytes_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          carve_we = 1'b1;
          if (claim) begin
            pages_nxt = pages_r + CNT_W'(1);
            alloc_nxt = alloc_r + BYTES_W'(PAGE_BYTES);
          end
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = carve_addr;
          mreq.wr_data = '{in_use: 1'b1, cls: k_r, link: '0};
          used_nxt       = used_r + size_k;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_addr_nxt   = carve_addr;
          out_bytes_nxt  = size_k[REQ_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      S_WB: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (cmd_r == CMD_ALLOC) begin
          // Pop: the popped block's link becomes the new top of stack.
          head_we        = 1'b1;
          head_wd        = rd_data.link;
          mreq.wr_en     = 1'b1;
          mreq.wr_addr   = head_r[kidx][ADDR_W-1:0];
          mreq.wr_data   = '{in_use: 1'b1, cls: k_r, link: '0};
          used_nxt       = used_r + size_k;
          out_status_nxt = STAT_OK;
          out_addr_nxt   = head_r[kidx][ADDR_W-1:0];
          out_bytes_nxt  = size_k[REQ_W-1:0];
        end else if (!rd_data.in_use || (rd_data.cls >= CLS_W'(NUM_CLASSES))) begin
          out_status_nxt = STAT_BAD_FREE;
          out_addr_nxt   = '0;
          out_bytes_nxt  = '0;
        end else begin
          head_we        = 1'b1;
          head_idx       = fidx;
          head_wd        = LINK_W'(faddr_r);
          mreq.wr_en     = 1'b1;
          mreq.wr_addr   = faddr_r;
          mreq.wr_data   = '{in_use: 1'b0, cls: rd_data.cls, link: head_r[fidx]};
          used_nxt       = used_r - size_f;
          out_status_nxt = STAT_OK;
          out_addr_nxt   = faddr_r;
          out_bytes_nxt  = size_f[REQ_W-1:0];
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pages_r     <= '0;
      alloc_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c]  <= EMPTY_MARK;
        cpage_r[c] <= '0;
        cleft_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_r + ADDR_W'(1);
      pages_r     <= pages_nxt;
      alloc_r     <= alloc_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) head_r[head_idx] <= head_wd;
      if (carve_we) begin
        cpage_r[kidx] <= cpage_wd;
        cleft_r[kidx] <= cleft_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_bytes_r  <= out_bytes_nxt;
    if (state_r == S_IDLE && start) begin
      cmd_r   <= in_command;
      k_r     <= class_of(in_request_bytes);
      faddr_r <= in_free_address;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_block_address   = out_addr_r;
  assign out_block_bytes     = out_bytes_r;
  assign out_allocated_bytes = alloc_r;
  assign out_used_bytes      = used_r;

endmodule
